FILE: hw/rtl/nmea_rmc_field_extractor_macros.svh
// Assertion macros used by the RMC parse module.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NMEA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nmea rmc assertion failed");

// Next-cycle implication, checked out of reset.
`define NMEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nmea rmc assertion failed");

`endif

FILE: hw/rtl/nmea_pkg.sv
// Types and constants for the RMC field extractor.
package nmea_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 3;
    localparam int INDEX_W = 4;
    localparam int FIELD_W = 4;
    localparam int HDR_W   = 3;
    localparam int TDATA_W = 16;

    // characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // header tracker: 0..6 bytes matched, then body
    localparam logic [HDR_W-1:0] HDR_SEARCH = 3'd0;
    localparam logic [HDR_W-1:0] HDR_G      = 3'd1;
    localparam logic [HDR_W-1:0] HDR_P      = 3'd2;
    localparam logic [HDR_W-1:0] HDR_R      = 3'd3;
    localparam logic [HDR_W-1:0] HDR_M      = 3'd4;
    localparam logic [HDR_W-1:0] HDR_C      = 3'd5;
    localparam logic [HDR_W-1:0] HDR_COMMA  = 3'd6;
    localparam logic [HDR_W-1:0] HDR_BODY   = 3'd7;

    // body field numbers
    localparam logic [FIELD_W-1:0] FN_TIME   = 4'd0;
    localparam logic [FIELD_W-1:0] FN_STATUS = 4'd1;
    localparam logic [FIELD_W-1:0] FN_LAT    = 4'd2;
    localparam logic [FIELD_W-1:0] FN_NS     = 4'd3;
    localparam logic [FIELD_W-1:0] FN_LON    = 4'd4;
    localparam logic [FIELD_W-1:0] FN_EW     = 4'd5;
    localparam logic [FIELD_W-1:0] FN_DATE   = 4'd8;
    localparam logic [FIELD_W-1:0] FN_MAX    = 4'd15;

    // output field codes
    localparam logic [CODE_W-1:0] FC_TIME   = 3'd0;
    localparam logic [CODE_W-1:0] FC_STATUS = 3'd1;
    localparam logic [CODE_W-1:0] FC_LAT    = 3'd2;
    localparam logic [CODE_W-1:0] FC_NS     = 3'd3;
    localparam logic [CODE_W-1:0] FC_LON    = 3'd4;
    localparam logic [CODE_W-1:0] FC_EW     = 3'd5;
    localparam logic [CODE_W-1:0] FC_DATE   = 3'd6;
    localparam logic [CODE_W-1:0] FC_END    = 3'd7;

    typedef struct packed {
        logic                fix_valid;
        logic [INDEX_W-1:0]  char_index;
        logic [BYTE_W-1:0]   char_value;
        logic [CODE_W-1:0]   field_code;
    } rec_t;

    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_W-1:0] st);
        logic [BYTE_W-1:0] ch;
        case (st)
            HDR_SEARCH: ch = CH_DOLLAR;
            HDR_G:      ch = CH_G;
            HDR_P:      ch = CH_P;
            HDR_R:      ch = CH_R;
            HDR_M:      ch = CH_M;
            HDR_C:      ch = CH_C;
            default:    ch = CH_COMMA;
        endcase
        return ch;
    endfunction

endpackage

FILE: hw/rtl/nmea_rmc_parse.sv
// Header match, field tracking and record decode for one byte per cycle.
`include "nmea_rmc_field_extractor_macros.svh"
module nmea_rmc_parse #(
    parameter int MAX_FIELD_CHARS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_word,
    input  logic [nmea_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         rec_emit,
    output nmea_pkg::rec_t               rec
);
    import nmea_pkg::*;

    localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);

    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ok_reg, ok_next;
    logic               first;
    logic [CNT_W+INDEX_W-1:0] idx_ext;

    assign first   = (cnt_reg == '0);
    assign idx_ext = {{INDEX_W{1'b0}}, cnt_reg};

    always_comb begin
        hdr_next   = hdr_reg;
        field_next = field_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        rec_emit   = 1'b0;
        rec.field_code = FC_TIME;
        rec.char_value = rx_byte;
        rec.char_index = idx_ext[INDEX_W-1:0];
        rec.fix_valid  = 1'b0;
        if (in_word) begin
            if (hdr_reg != HDR_BODY) begin
                if (rx_byte == hdr_char(hdr_reg)) begin
                    hdr_next = hdr_reg + HDR_W'(1);
                    if (hdr_reg == HDR_COMMA) begin
                        field_next = FN_TIME;
                        cnt_next   = '0;
                        ok_next    = 1'b0;
                    end
                end else begin
                    hdr_next = HDR_SEARCH;
                end
            end else if (rx_byte == CH_CR) begin
                rec_emit       = 1'b1;
                rec.field_code = FC_END;
                rec.char_value = '0;
                rec.char_index = '0;
                rec.fix_valid  = ok_reg;
                hdr_next   = HDR_SEARCH;
                field_next = FN_TIME;
                cnt_next   = '0;
                ok_next    = 1'b0;
            end else if (rx_byte == CH_COMMA) begin
                if (field_reg != FN_MAX) begin
                    field_next = field_reg + FIELD_W'(1);
                end
                cnt_next = '0;
            end else if (cnt_reg < CNT_W'(MAX_FIELD_CHARS)) begin
                cnt_next = cnt_reg + CNT_W'(1);
                case (field_reg)
                    FN_TIME: begin
                        rec_emit       = 1'b1;
                        rec.field_code = FC_TIME;
                    end
                    FN_STATUS: begin
                        if (first) begin
                            ok_next        = (rx_byte == CH_A);
                            rec_emit       = 1'b1;
                            rec.field_code = FC_STATUS;
                        end
                    end
                    FN_LAT: begin
                        rec_emit       = ok_reg;
                        rec.field_code = FC_LAT;
                    end
                    FN_NS: begin
                        rec_emit       = ok_reg && first;
                        rec.field_code = FC_NS;
                    end
                    FN_LON: begin
                        rec_emit       = ok_reg;
                        rec.field_code = FC_LON;
                    end
                    FN_EW: begin
                        rec_emit       = ok_reg && first;
                        rec.field_code = FC_EW;
                    end
                    FN_DATE: begin
                        rec_emit       = ok_reg;
                        rec.field_code = FC_DATE;
                    end
                    default: rec_emit = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg   <= HDR_SEARCH;
            field_reg <= FN_TIME;
            cnt_reg   <= '0;
            ok_reg    <= 1'b0;
        end else begin
            hdr_reg   <= hdr_next;
            field_reg <= field_next;
            cnt_reg   <= cnt_next;
            ok_reg    <= ok_next;
        end
    end

    // position and date data only leave while an 'A' status is latched
    `NMEA_ASSERT_NOW(a_pos_needs_fix, aclk, aresetn,
        rec_emit && rec.field_code != FC_TIME && rec.field_code != FC_STATUS
            && rec.field_code != FC_END, ok_reg)
    // records are produced only from the body
    `NMEA_ASSERT_NOW(a_emit_in_body, aclk, aresetn, rec_emit, hdr_reg == HDR_BODY)
    // CR in the body rearms the header search
    `NMEA_ASSERT_NEXT(a_cr_rearms, aclk, aresetn,
        in_word && hdr_reg == HDR_BODY && rx_byte == CH_CR,
        hdr_reg == HDR_SEARCH && field_reg == FN_TIME && !ok_reg)
    // the field character count never passes the limit
    `NMEA_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1,
        cnt_reg <= CNT_W'(MAX_FIELD_CHARS))

endmodule

FILE: hw/rtl/nmea_rmc_outreg.sv
// Result register that holds one record until the downstream side takes it.
module nmea_rmc_outreg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  nmea_pkg::rec_t  rec,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output nmea_pkg::rec_t  out_rec
);
    import nmea_pkg::*;

    logic valid_reg, valid_next;
    rec_t rec_reg;

    // a held word that is taken this cycle frees the slot for the next one
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

FILE: hw/rtl/nmea_rmc_field_extractor.sv
// Top level: extracts RMC time, status, position and date characters from a byte stream.
// A record appears on m_ the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; s_tready drops only while a record waits on m_tready.
// A record-free byte (header, comma, skipped field) emits nothing.
// Reset: synchronous, active low; returns to header search and empties the result register.
module nmea_rmc_field_extractor #(
    parameter int MAX_FIELD_CHARS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nmea_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nmea_pkg::TDATA_W-1:0]  m_tdata    // [2:0] field_code, [10:3] char_value,
                                                     // [14:11] char_index, [15] fix_valid
);
    import nmea_pkg::*;

    logic in_word;
    logic rec_emit;
    rec_t rec;
    rec_t out_rec;

    assign in_word = s_tvalid && s_tready;

    nmea_rmc_parse #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (in_word),
        .rx_byte  (s_tdata),
        .rec_emit (rec_emit),
        .rec      (rec)
    );

    nmea_rmc_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (rec_emit),
        .rec       (rec),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign m_tdata = out_rec;

endmodule
